@@ design/assert_macros.svh @@
// Assertion macros used by the free segment allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

@@ design/fsa_pkg.sv @@
// Types and constants of the free segment allocator.
package fsa_pkg;

  localparam int unsigned SEGMENTS_DEFAULT = 32;

  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_BEST  = 2'd1;
  localparam logic [1:0] STRAT_NEXT  = 2'd2;
  localparam logic [1:0] STRAT_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [31:0] ADDR_TOP = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] len;
    logic [31:0] start;
  } seg_t;

endpackage

@@ design/fsa_table.sv @@
// Segment table memory: one write port, one registered read port.
module fsa_table #(
  parameter int unsigned SEGMENTS = fsa_pkg::SEGMENTS_DEFAULT,
  parameter int unsigned IW       = $clog2(SEGMENTS)
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [IW-1:0]  waddr_i,
  input  fsa_pkg::seg_t  wdata_i,
  input  logic [IW-1:0]  raddr_i,
  output fsa_pkg::seg_t  rdata_o
);

  fsa_pkg::seg_t mem [SEGMENTS];
  fsa_pkg::seg_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/free_segment_allocator.sv @@
// Free segment allocator: address-sorted free table with fit search and coalescing.
// Scans and shifts step through the table entries in order over the single table port.
// Throughput: one transaction at a time; a new one is taken while a result waits.
// Reset: asynchronous, table empty, strategy first fit; no clearing pass.
`include "assert_macros.svh"

module free_segment_allocator #(
  parameter int unsigned SEGMENTS = fsa_pkg::SEGMENTS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // request_size [31:0], segment_address [63:32]
  input  logic        s_axis_tuser_i,   // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // granted_address [31:0]
  output logic [1:0]  m_axis_tuser_o,   // status [1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i        // placement_strategy
);

  localparam int unsigned IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] SEG_N = CW'(SEGMENTS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_START   = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_ALLOC   = 4'd3;
  localparam logic [3:0] S_FDEC    = 4'd4;
  localparam logic [3:0] S_FWR     = 4'd5;
  localparam logic [3:0] S_MERGE   = 4'd6;
  localparam logic [3:0] S_SHDN    = 4'd7;
  localparam logic [3:0] S_SHUP    = 4'd8;
  localparam logic [3:0] S_INSWR   = 4'd9;
  localparam logic [3:0] S_POST    = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [1:0]    strat_q, strat_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] nfi_q, nfi_d;
  logic          mode_q, mode_d;
  logic [31:0]   size_q, size_d;
  logic [31:0]   addr_q, addr_d;
  logic [31:0]   end_q, end_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] n_q, n_d;
  logic [IW-1:0] found_q, found_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [IW-1:0] k_q, k_d;
  logic          hit_q, hit_d;
  logic          rem_q, rem_d;
  logic          ins_q, ins_d;
  logic          okal_q, okal_d;
  logic          mp_q, mp_d;
  logic          mn_q, mn_d;
  fsa_pkg::seg_t f_q, f_d;
  fsa_pkg::seg_t prev_q, prev_d;
  logic          prev_ok_q, prev_ok_d;
  fsa_pkg::seg_t next_q, next_d;
  logic          next_ok_q, next_ok_d;
  logic [31:0]   sum_q, sum_d;
  logic [31:0]   grant_q, grant_d;
  logic [1:0]    status_q, status_d;
  logic          mval_q, mval_d;
  logic [31:0]   oaddr_q, oaddr_d;
  logic [1:0]    ostat_q, ostat_d;

  logic          we;
  logic [IW-1:0] waddr;
  fsa_pkg::seg_t wdata;
  logic [IW-1:0] raddr;
  fsa_pkg::seg_t rdata;

  logic [32:0]   end33;
  logic [32:0]   prev_end;
  logic [CW-1:0] idx_inc;
  logic [IW-1:0] idx_nx;
  logic          last;
  logic          fit;
  logic [CW-1:0] cnt_n;
  logic [CW-1:0] nfi_w;

  fsa_table #(
    .SEGMENTS (SEGMENTS),
    .IW       (IW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = mval_q;
  assign m_axis_tdata_o  = oaddr_q;
  assign m_axis_tuser_o  = ostat_q;

  assign end33    = {1'b0, addr_q} + {1'b0, size_q};
  assign prev_end = {1'b0, prev_q.start} + {1'b0, prev_q.len};
  assign idx_inc  = {1'b0, idx_q} + CW'(1);
  assign idx_nx   = (idx_inc == cnt_q) ? '0 : idx_inc[IW-1:0];
  assign last     = ((n_q + CW'(1)) == cnt_q);
  assign fit      = (rdata.len >= size_q) && (!hit_q || (rdata.len < f_q.len));

  always_comb begin
    state_d   = state_q;
    strat_d   = strat_q;
    cnt_d     = cnt_q;
    nfi_d     = nfi_q;
    mode_d    = mode_q;
    size_d    = size_q;
    addr_d    = addr_q;
    end_d     = end_q;
    idx_d     = idx_q;
    n_d       = n_q;
    found_d   = found_q;
    pos_d     = pos_q;
    k_d       = k_q;
    hit_d     = hit_q;
    rem_d     = rem_q;
    ins_d     = ins_q;
    okal_d    = okal_q;
    mp_d      = mp_q;
    mn_d      = mn_q;
    f_d       = f_q;
    prev_d    = prev_q;
    prev_ok_d = prev_ok_q;
    next_d    = next_q;
    next_ok_d = next_ok_q;
    sum_d     = sum_q;
    grant_d   = grant_q;
    status_d  = status_q;
    mval_d    = mval_q;
    oaddr_d   = oaddr_q;
    ostat_d   = ostat_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = '0;
    cnt_n     = cnt_q;
    nfi_w     = {1'b0, nfi_q};

    if (cfg_valid_i) begin
      strat_d = (cfg_data_i == fsa_pkg::STRAT_RSVD) ? fsa_pkg::STRAT_FIRST : cfg_data_i;
    end
    if (mval_q && m_axis_tready_i) begin
      mval_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          mode_d  = s_axis_tuser_i;
          size_d  = s_axis_tdata_i[31:0];
          addr_d  = s_axis_tdata_i[63:32];
          state_d = S_START;
        end
      end
      S_START: begin
        grant_d   = '0;
        status_d  = fsa_pkg::ST_OK;
        rem_d     = 1'b0;
        ins_d     = 1'b0;
        okal_d    = 1'b0;
        hit_d     = 1'b0;
        prev_ok_d = 1'b0;
        next_ok_d = 1'b0;
        n_d       = '0;
        idx_d     = (mode_q == fsa_pkg::MODE_ALLOC && strat_q == fsa_pkg::STRAT_NEXT &&
                     {1'b0, nfi_q} < cnt_q) ? nfi_q : '0;
        raddr     = idx_d;
        if (mode_q == fsa_pkg::MODE_FREE) begin
          if (end33[32]) begin
            size_d = ~addr_q;
            end_d  = fsa_pkg::ADDR_TOP;
          end else begin
            end_d = end33[31:0];
          end
          if (size_q == '0 || addr_q == fsa_pkg::ADDR_TOP) begin
            state_d = S_DONE;
          end else if (cnt_q == '0) begin
            pos_d   = '0;
            state_d = S_FDEC;
          end else begin
            state_d = S_SCAN;
          end
        end else if (size_q == '0 || cnt_q == '0) begin
          status_d = fsa_pkg::ST_NOFIT;
          state_d  = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        raddr = idx_nx;
        n_d   = n_q + CW'(1);
        idx_d = idx_nx;
        if (mode_q == fsa_pkg::MODE_FREE) begin
          if (rdata.start > addr_q) begin
            pos_d     = {1'b0, idx_q};
            next_d    = rdata;
            next_ok_d = 1'b1;
            state_d   = S_FDEC;
          end else begin
            prev_d    = rdata;
            prev_ok_d = 1'b1;
            if (last) begin
              pos_d   = cnt_q;
              state_d = S_FDEC;
            end
          end
        end else if (strat_q == fsa_pkg::STRAT_BEST) begin
          if (fit) begin
            f_d     = rdata;
            found_d = idx_q;
            hit_d   = 1'b1;
          end
          if (last) begin
            if (hit_q || fit) begin
              state_d = S_ALLOC;
            end else begin
              status_d = fsa_pkg::ST_NOFIT;
              state_d  = S_DONE;
            end
          end
        end else begin
          if (rdata.len >= size_q) begin
            f_d     = rdata;
            found_d = idx_q;
            state_d = S_ALLOC;
          end else if (last) begin
            status_d = fsa_pkg::ST_NOFIT;
            state_d  = S_DONE;
          end
        end
      end
      S_ALLOC: begin
        grant_d = f_q.start;
        okal_d  = 1'b1;
        if (f_q.len == size_q) begin
          rem_d = 1'b1;
          pos_d = {1'b0, found_q};
          k_d   = found_q;
          raddr = IW'({1'b0, found_q} + CW'(1));
          if (({1'b0, found_q} + CW'(1)) < cnt_q) begin
            state_d = S_SHDN;
          end else begin
            state_d = S_POST;
          end
        end else begin
          we          = 1'b1;
          waddr       = found_q;
          wdata.start = f_q.start + size_q;
          wdata.len   = f_q.len - size_q;
          state_d     = S_POST;
        end
      end
      S_SHDN: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = rdata;
        raddr = IW'({1'b0, k_q} + CW'(2));
        if (({1'b0, k_q} + CW'(2)) < cnt_q) begin
          k_d = k_q + IW'(1);
        end else begin
          state_d = S_POST;
        end
      end
      S_FDEC: begin
        mp_d  = prev_ok_q && (prev_end == {1'b0, addr_q});
        mn_d  = next_ok_q && (next_q.start == end_q);
        raddr = IW'(cnt_q - CW'(1));
        k_d   = cnt_q[IW-1:0];
        if (mp_d || mn_d) begin
          state_d = S_FWR;
        end else if (cnt_q == SEG_N) begin
          status_d = fsa_pkg::ST_FULL;
          state_d  = S_DONE;
        end else begin
          ins_d = 1'b1;
          if (cnt_q > pos_q) begin
            state_d = S_SHUP;
          end else begin
            state_d = S_INSWR;
          end
        end
      end
      S_FWR: begin
        if (mp_q && mn_q) begin
          sum_d   = prev_q.len + size_q;
          state_d = S_MERGE;
        end else if (mp_q) begin
          we          = 1'b1;
          waddr       = IW'(pos_q - CW'(1));
          wdata.start = prev_q.start;
          wdata.len   = prev_q.len + size_q;
          state_d     = S_POST;
        end else begin
          we          = 1'b1;
          waddr       = pos_q[IW-1:0];
          wdata.start = addr_q;
          wdata.len   = next_q.len + size_q;
          state_d     = S_POST;
        end
      end
      S_MERGE: begin
        we          = 1'b1;
        waddr       = IW'(pos_q - CW'(1));
        wdata.start = prev_q.start;
        wdata.len   = sum_q + next_q.len;
        rem_d       = 1'b1;
        k_d         = pos_q[IW-1:0];
        raddr       = IW'(pos_q + CW'(1));
        if ((pos_q + CW'(1)) < cnt_q) begin
          state_d = S_SHDN;
        end else begin
          state_d = S_POST;
        end
      end
      S_SHUP: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = rdata;
        raddr = k_q - IW'(2);
        if (({1'b0, k_q} - CW'(1)) > pos_q) begin
          k_d = k_q - IW'(1);
        end else begin
          state_d = S_INSWR;
        end
      end
      S_INSWR: begin
        we          = 1'b1;
        waddr       = pos_q[IW-1:0];
        wdata.start = addr_q;
        wdata.len   = size_q;
        state_d     = S_POST;
      end
      S_POST: begin
        if (rem_q) begin
          cnt_n = cnt_q - CW'(1);
          if (pos_q < {1'b0, nfi_q}) begin
            nfi_w = {1'b0, nfi_q} - CW'(1);
          end
        end else if (ins_q) begin
          cnt_n = cnt_q + CW'(1);
          if (pos_q <= {1'b0, nfi_q}) begin
            nfi_w = {1'b0, nfi_q} + CW'(1);
          end
        end
        if (nfi_w >= cnt_n) begin
          nfi_w = '0;
        end
        if (okal_q && strat_q == fsa_pkg::STRAT_NEXT) begin
          nfi_w = ({1'b0, found_q} >= cnt_n) ? '0 : {1'b0, found_q};
        end
        cnt_d   = cnt_n;
        nfi_d   = nfi_w[IW-1:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!mval_q || m_axis_tready_i) begin
          mval_d  = 1'b1;
          oaddr_d = grant_q;
          ostat_d = status_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      strat_q <= fsa_pkg::STRAT_FIRST;
      cnt_q   <= '0;
      nfi_q   <= '0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      strat_q <= strat_d;
      cnt_q   <= cnt_d;
      nfi_q   <= nfi_d;
      mval_q  <= mval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    size_q    <= size_d;
    addr_q    <= addr_d;
    end_q     <= end_d;
    idx_q     <= idx_d;
    n_q       <= n_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
    k_q       <= k_d;
    hit_q     <= hit_d;
    rem_q     <= rem_d;
    ins_q     <= ins_d;
    okal_q    <= okal_d;
    mp_q      <= mp_d;
    mn_q      <= mn_d;
    f_q       <= f_d;
    prev_q    <= prev_d;
    prev_ok_q <= prev_ok_d;
    next_q    <= next_d;
    next_ok_q <= next_ok_d;
    sum_q     <= sum_d;
    grant_q   <= grant_d;
    status_q  <= status_d;
    oaddr_q   <= oaddr_d;
    ostat_q   <= ostat_d;
  end

  `ASSERT_PROP(a_cnt_bound, cnt_q <= SEG_N)
  `ASSERT_PROP(a_nfi_range, ({1'b0, nfi_q} < cnt_q) || (nfi_q == '0))
  `ASSERT_IMPL(a_rise_from_done, $rose(mval_q), $past(state_q) == S_DONE)
  `ASSERT_IMPL(a_zero_grant, mval_q && (ostat_q != fsa_pkg::ST_OK), oaddr_q == '0)
  `ASSERT_IMPL(a_cnt_only_post, cnt_q != $past(cnt_q), $past(state_q) == S_POST)

endmodule

@@ verif/free_segment_allocator_tb.sv @@
// Self-checking testbench of the free segment allocator: table predictor, driver, monitor.
`timescale 1ns / 1ps

module free_segment_allocator_tb;

  localparam int unsigned SEGS     = 32;
  localparam int unsigned IDLE_GAP = 100;
  localparam int unsigned WD_LIMIT = 5000;
  localparam int unsigned HOLD_LEN = 400;
  localparam logic [1:0]  STRAT_SEQ [7] = '{fsa_pkg::STRAT_BEST, fsa_pkg::STRAT_NEXT,
                                            fsa_pkg::STRAT_RSVD, fsa_pkg::STRAT_NEXT,
                                            fsa_pkg::STRAT_FIRST, fsa_pkg::STRAT_BEST,
                                            fsa_pkg::STRAT_NEXT};

  typedef struct {
    logic        mode;
    logic [31:0] size;
    logic [31:0] addr;
  } request_t;

  typedef struct {
    logic [31:0] grant;
    logic [1:0]  status;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_data = '0;
  logic        s_tready, m_tvalid, cfg_ready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  request_t    pending_requests[$];
  grant_t      expected_grants[$];
  request_t    cur_req;
  int unsigned send_gap = 0, recv_gap = 0, wd_count = 0, errors = 0, results_seen = 0;
  logic        calm = 1'b0, hold = 1'b0, busy;

  // predictor state
  logic [31:0] tbl_start[SEGS];
  logic [31:0] tbl_len[SEGS];
  int unsigned tbl_cnt = 0, nf_idx = 0;
  logic [1:0]  strat_model = fsa_pkg::STRAT_FIRST;

  free_segment_allocator #(.SEGMENTS(SEGS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clamp_index();
    if (nf_idx >= tbl_cnt) nf_idx = 0;
  endfunction

  function automatic void seg_remove(int unsigned i);
    for (int unsigned k = i; k + 1 < tbl_cnt; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_len[k]   = tbl_len[k+1];
    end
    tbl_cnt--;
    if (i < nf_idx) nf_idx--;
    clamp_index();
  endfunction

  function automatic void seg_insert(int unsigned p, logic [31:0] st, logic [31:0] ln);
    for (int unsigned k = tbl_cnt; k > p; k--) begin
      tbl_start[k] = tbl_start[k-1];
      tbl_len[k]   = tbl_len[k-1];
    end
    tbl_start[p] = st;
    tbl_len[p]   = ln;
    tbl_cnt++;
    if (p <= nf_idx) nf_idx++;
    clamp_index();
  endfunction

  function automatic bit seg_pick(logic [31:0] size, output int unsigned found);
    bit hit = 1'b0;
    int unsigned s, i;
    found = 0;
    if (strat_model == fsa_pkg::STRAT_BEST) begin
      for (i = 0; i < tbl_cnt; i++)
        if (tbl_len[i] >= size && (!hit || tbl_len[i] < tbl_len[found])) begin
          found = i;
          hit = 1'b1;
        end
      return hit;
    end
    s = (strat_model == fsa_pkg::STRAT_NEXT && nf_idx < tbl_cnt) ? nf_idx : 0;
    for (int unsigned n = 0; n < tbl_cnt; n++) begin
      i = s + n;
      if (i >= tbl_cnt) i -= tbl_cnt;
      if (tbl_len[i] >= size) begin
        found = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] seg_release(logic [31:0] addr, logic [31:0] size);
    logic [32:0] seg_end;
    int unsigned p = 0;
    bit mprev, mnext;
    if (size == 0 || addr == fsa_pkg::ADDR_TOP) return fsa_pkg::ST_OK;
    seg_end = {1'b0, addr} + {1'b0, size};
    if (seg_end > {1'b0, fsa_pkg::ADDR_TOP}) begin
      size = fsa_pkg::ADDR_TOP - addr;
      seg_end = {1'b0, fsa_pkg::ADDR_TOP};
    end
    while (p < tbl_cnt && tbl_start[p] <= addr) p++;
    mprev = p > 0 && ({1'b0, tbl_start[p-1]} + {1'b0, tbl_len[p-1]}) == {1'b0, addr};
    mnext = p < tbl_cnt && {1'b0, tbl_start[p]} == seg_end;
    if (mprev && mnext) begin
      tbl_len[p-1] = tbl_len[p-1] + size + tbl_len[p];
      seg_remove(p);
    end else if (mprev) begin
      tbl_len[p-1] += size;
    end else if (mnext) begin
      tbl_start[p] = addr;
      tbl_len[p] += size;
    end else begin
      if (tbl_cnt >= SEGS) return fsa_pkg::ST_FULL;
      seg_insert(p, addr, size);
    end
    return fsa_pkg::ST_OK;
  endfunction

  function automatic grant_t serve_request(request_t r);
    grant_t g;
    int unsigned i;
    g.grant = '0;
    if (r.mode == fsa_pkg::MODE_FREE) begin
      g.status = seg_release(r.addr, r.size);
    end else if (r.size == 0 || !seg_pick(r.size, i)) begin
      g.status = fsa_pkg::ST_NOFIT;
    end else begin
      g.status = fsa_pkg::ST_OK;
      g.grant = tbl_start[i];
      if (tbl_len[i] == r.size) begin
        seg_remove(i);
      end else begin
        tbl_start[i] += r.size;
        tbl_len[i] -= r.size;
      end
      if (strat_model == fsa_pkg::STRAT_NEXT) begin
        nf_idx = i;
        clamp_index();
      end
    end
    return g;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int unsigned draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic void push_req(logic mode, logic [31:0] size, logic [31:0] addr);
    request_t r;
    r.mode = mode;
    r.size = size;
    r.addr = addr;
    pending_requests.push_back(r);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        expected_grants.push_back(serve_request(cur_req));
        busy = 1'b0;
        send_gap = draw_gap();
      end
      if (!busy) begin
        if (send_gap == 0 && pending_requests.size() > 0) begin
          cur_req = pending_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_req.addr, cur_req.size};
          s_tuser  <= cur_req.mode;
        end else begin
          s_tvalid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_grants.size() == 0) begin
          report("unexpected result", m_tdata, '0);
        end else begin
          grant_t g;
          g = expected_grants.pop_front();
          if (m_tdata !== g.grant) report("granted_address", m_tdata, g.grant);
          if (m_tuser !== g.status) report("status", {30'd0, m_tuser}, {30'd0, g.status});
        end
        recv_gap = draw_gap();
      end
      if (hold) begin
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        m_tready <= 1'b0;
        recv_gap--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      wd_count <= 0;
    end else if (rst_ni) begin
      wd_count <= wd_count + 1;
      if (wd_count >= WD_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // long receiver hold-off so the input side backs up
  initial begin
    wait (results_seen >= 300);
    @(posedge clk_i);
    hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold <= 1'b0;
  end

  task automatic drain();
    wait (pending_requests.size() == 0 && !s_tvalid && expected_grants.size() == 0);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  task automatic write_strategy(logic [1:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    strat_model = (v == fsa_pkg::STRAT_RSVD) ? fsa_pkg::STRAT_FIRST : v;
  endtask

  task automatic fill_random(int unsigned n);
    logic [31:0] base = 32'h1000_0000;
    logic [31:0] b;
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        push_req(fsa_pkg::MODE_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4096)
                 : $urandom_range(1, 4) * 16, $urandom);
      end else if (r < 85) begin
        push_req(fsa_pkg::MODE_FREE, $urandom_range(1, 8) * 16,
                 base + $urandom_range(0, 255) * 16);
      end else if (r < 88) begin
        b = $urandom & 32'hFFF0_0000;
        for (int k = 0; k < 36; k++) push_req(fsa_pkg::MODE_FREE, 32'h10, b + 32'(k) * 32'h100);
      end else begin
        push_req(1'($urandom_range(0, 1)), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_req(fsa_pkg::MODE_ALLOC, 32'd0, 32'h0);
    push_req(fsa_pkg::MODE_ALLOC, 32'd5, 32'h0);
    push_req(fsa_pkg::MODE_FREE, 32'd0, 32'h100);
    push_req(fsa_pkg::MODE_FREE, 32'd10, fsa_pkg::ADDR_TOP);
    push_req(fsa_pkg::MODE_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    push_req(fsa_pkg::MODE_FREE, 32'h100, 32'h0);
    push_req(fsa_pkg::MODE_FREE, 32'h100, 32'h200);
    push_req(fsa_pkg::MODE_FREE, 32'h100, 32'h100);
    push_req(fsa_pkg::MODE_FREE, 32'h80, 32'h400);
    push_req(fsa_pkg::MODE_FREE, 32'h80, 32'h380);
    push_req(fsa_pkg::MODE_FREE, 32'h10, 32'h480);
    push_req(fsa_pkg::MODE_ALLOC, 32'h300, 32'hFFFF_FFFF);
    push_req(fsa_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'h0);
    push_req(fsa_pkg::MODE_ALLOC, 32'd1, 32'h0);
    push_req(fsa_pkg::MODE_FREE, 32'h20, 32'h390);
    push_req(fsa_pkg::MODE_ALLOC, 32'd15, 32'h5A5A_5A5A);
    push_req(fsa_pkg::MODE_ALLOC, 32'h10, 32'h0);
    push_req(fsa_pkg::MODE_FREE, 32'h7FFF_FFFF, 32'h8000_0000);
    push_req(fsa_pkg::MODE_ALLOC, 32'h4000_0000, 32'h0);
    push_req(fsa_pkg::MODE_FREE, 32'hFFFF_FFFF, 32'h0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_strategy(STRAT_SEQ[ph]);
      calm = (ph == 4);
      fill_random(86);
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
